/* hdl/odo_pkg.sv */
// odo_pkg: shared constants, types and helper functions of the offset direction orderer
// no dependencies; compiled first
`default_nettype none

package odo_pkg;

	localparam int MAX_JOINTS   = 8;
	localparam int OFFSET_WIDTH = 16;
	localparam int DIR_W        = 4;
	localparam int JIDX_W       = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
	localparam int CNT_W        = $clog2(MAX_JOINTS + 1);
	localparam int RUN_W        = $clog2(2 * MAX_JOINTS + 1);

	typedef logic signed [OFFSET_WIDTH-1:0] offset_t;
	typedef logic [OFFSET_WIDTH-1:0]        mag_t;
	typedef logic [JIDX_W-1:0]              jidx_t;
	typedef logic [CNT_W-1:0]               cnt_t;
	typedef logic [RUN_W-1:0]               run_t;
	typedef logic [DIR_W-1:0]               dir_t;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_FETCH,
		ST_CMP,
		ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		PH_FWD,
		PH_ZERO,
		PH_REV
	} phase_t;

	// absolute value; the most negative code maps to 2^(w-1)
	function automatic mag_t magnitude(offset_t v);
		mag_t m;
		m = v[OFFSET_WIDTH-1] ? mag_t'(-v) : mag_t'(v);
		return m;
	endfunction

	// 2*joint plus the step bit, fitted to the index width
	function automatic dir_t dir_index(jidx_t jt, logic pos);
		logic [JIDX_W:0] raw;
		raw = {jt, pos};
		return dir_t'(raw);
	endfunction

endpackage

`default_nettype wire

/* hdl/odo_in_if.sv */
// odo_in_if: valid/ready channel carrying one joint offset per transaction
// depends on odo_pkg
`default_nettype none

interface odo_in_if import odo_pkg::*; ();
	logic    valid;
	logic    ready;
	offset_t joint_offset;
	logic    last_joint;

	modport source (output valid, output joint_offset, output last_joint, input ready);
	modport sink   (input valid, input joint_offset, input last_joint, output ready);
endinterface

`default_nettype wire

/* hdl/odo_out_if.sv */
// odo_out_if: valid/ready channel carrying one move direction index per transaction
// depends on odo_pkg
`default_nettype none

interface odo_out_if import odo_pkg::*; ();
	logic valid;
	logic ready;
	dir_t direction_index;
	logic last_of_run;
	logic overflow;

	modport source (output valid, output direction_index, output last_of_run,
		output overflow, input ready);
	modport sink   (input valid, input direction_index, input last_of_run,
		input overflow, output ready);
endinterface

`default_nettype wire

/* hdl/offset_direction_orderer.sv */
// offset_direction_orderer: collects joint offsets, ranks them by magnitude and emits
// the 2N move direction indices; depends on odo_pkg, odo_in_if, odo_out_if
// input accepts offset transactions while loading; after the last joint the
// ranking does one magnitude compare per cycle in a shared comparator;
// emission then walks the ranking three times and holds a result while the result
// side stalls; zero joints rank first and the forward pass skips them
// input opens again the cycle after the run's final step
// reset clears the joint count, the dropped flag, the sequencer and the output valid;
// the offset and ranking registers hold no reset value and are written before use
`default_nettype none

module offset_direction_orderer import odo_pkg::*; (
	input  wire         clk,
	input  wire         arst_n,
	odo_in_if.sink      joint,
	odo_out_if.source   move
);

	// stored vector and ranking
	offset_t offset_q [MAX_JOINTS];
	jidx_t   order_q  [MAX_JOINTS];
	cnt_t    count_q;
	logic    dropped_q;

	// sequencer
	state_t  state_q, state_d;
	phase_t  phase_q;
	jidx_t   i_q, j_q, rank_q, r_q;
	mag_t    mag_i_q;
	logic    half_q;
	run_t    k_q;

	// output register
	logic    out_valid_q;
	dir_t    out_dir_q;
	logic    out_last_q;
	logic    out_ovf_q;

	// combinational control
	cnt_t    last_idx;
	jidx_t   jt;
	jidx_t   rd_addr;
	offset_t off_rd;
	mag_t    mag_rd;
	logic    less;
	logic    nz, neg;
	logic    want, slot_ok, advance, emit;
	dir_t    idx;
	logic    in_acc;
	logic    at_last_r, at_last_j, at_last_i;

	assign in_acc   = joint.valid && joint.ready;
	assign last_idx = count_q - cnt_t'(1);

	// one read port into the offset registers, shared by ranking and emission
	assign jt      = order_q[r_q];
	assign rd_addr = (state_q == ST_FETCH) ? i_q :
	                 (state_q == ST_CMP)   ? j_q : jt;
	assign off_rd  = offset_q[rd_addr];
	assign mag_rd  = magnitude(off_rd);

	// stable rank compare: smaller magnitude, or equal and lower index
	assign less = (mag_rd < mag_i_q) || ((mag_rd == mag_i_q) && (j_q < i_q));

	assign nz  = (off_rd != '0);
	assign neg = off_rd[OFFSET_WIDTH-1];

	assign at_last_r = (cnt_t'(r_q) == last_idx);
	assign at_last_j = (cnt_t'(j_q) == last_idx);
	assign at_last_i = (cnt_t'(i_q) == last_idx);

	assign slot_ok = !out_valid_q || move.ready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD: begin
				if (in_acc && joint.last_joint) state_d = ST_FETCH;
			end
			ST_FETCH: begin
				state_d = ST_CMP;
			end
			ST_CMP: begin
				if (at_last_j) state_d = at_last_i ? ST_EMIT : ST_FETCH;
			end
			ST_EMIT: begin
				if (advance && (phase_q == PH_REV) && (r_q == '0)) state_d = ST_LOAD;
			end
			default: state_d = ST_LOAD;
		endcase
	end

	// sequencer outputs
	always_comb begin
		want         = 1'b0;
		idx          = '0;
		joint.ready  = (state_q == ST_LOAD);
		case (phase_q)
			PH_FWD: begin
				want = nz;
				idx  = dir_index(jt, !neg);
			end
			PH_ZERO: begin
				want = !nz;
				idx  = dir_index(jt, half_q);
			end
			PH_REV: begin
				want = nz;
				idx  = dir_index(jt, neg);
			end
			default: begin
				want = 1'b0;
				idx  = '0;
			end
		endcase
		advance = (state_q == ST_EMIT) && (!want || slot_ok);
		emit    = advance && want;
	end

	// load path and run bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			dropped_q <= 1'b0;
		end else if (in_acc) begin
			if (count_q < cnt_t'(MAX_JOINTS)) count_q <= count_q + cnt_t'(1);
			else dropped_q <= 1'b1;
		end else if (state_q == ST_EMIT && state_d == ST_LOAD) begin
			count_q   <= '0;
			dropped_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && (count_q < cnt_t'(MAX_JOINTS)))
			offset_q[count_q[JIDX_W-1:0]] <= joint.joint_offset;
		if (state_q == ST_CMP && at_last_j)
			order_q[rank_q + jidx_t'(less)] <= i_q;
	end

	// sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			phase_q <= PH_FWD;
			i_q     <= '0;
			j_q     <= '0;
			rank_q  <= '0;
			r_q     <= '0;
			half_q  <= 1'b0;
			k_q     <= '0;
			mag_i_q <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_LOAD: begin
					i_q <= '0;
				end
				ST_FETCH: begin
					mag_i_q <= mag_rd;
					j_q     <= '0;
					rank_q  <= '0;
				end
				ST_CMP: begin
					rank_q <= rank_q + jidx_t'(less);
					j_q    <= j_q + jidx_t'(1);
					if (at_last_j) begin
						i_q     <= i_q + jidx_t'(1);
						r_q     <= '0;
						phase_q <= PH_FWD;
						half_q  <= 1'b0;
						k_q     <= '0;
					end
				end
				ST_EMIT: begin
					if (emit) k_q <= k_q + run_t'(1);
					if (advance) begin
						case (phase_q)
							PH_FWD: begin
								if (at_last_r) begin
									phase_q <= PH_ZERO;
									r_q     <= '0;
								end else begin
									r_q <= r_q + jidx_t'(1);
								end
							end
							PH_ZERO: begin
								// a zero joint goes out twice, negative step first
								if (want && !half_q) begin
									half_q <= 1'b1;
								end else begin
									half_q <= 1'b0;
									if (at_last_r) begin
										phase_q <= PH_REV;
										r_q     <= last_idx[JIDX_W-1:0];
									end else begin
										r_q <= r_q + jidx_t'(1);
									end
								end
							end
							PH_REV: begin
								if (r_q != '0) r_q <= r_q - jidx_t'(1);
							end
							default: phase_q <= PH_FWD;
						endcase
					end
				end
				default: ;
			endcase
		end
	end

	// output register, parts the sequencer from the result side
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (move.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_dir_q  <= idx;
			out_last_q <= (k_q == (run_t'({count_q, 1'b0}) - run_t'(1)));
			out_ovf_q  <= dropped_q;
		end
	end

	assign move.valid           = out_valid_q;
	assign move.direction_index = out_dir_q;
	assign move.last_of_run     = out_last_q;
	assign move.overflow        = out_ovf_q;

	// checks
	a_last_closes_input: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && joint.last_joint) |=> !joint.ready)
		else $error("input still open after the last joint");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= cnt_t'(MAX_JOINTS))
		else $error("joint count beyond store depth");

	// the reverse pass may still skip zero joints after the final result
	a_run_length: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (k_q <= run_t'({count_q, 1'b0})))
		else $error("more results than 2N in one run");

	a_rank_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CMP) |-> (cnt_t'(rank_q) <= last_idx))
		else $error("rank beyond stored joints");

endmodule

`default_nettype wire
